@@ src/ubxfr_pkg.sv @@
// ----------------------------------------------------------------------------
// ubxfr_pkg
// Shared types and constants of the binary GNSS frame receiver: byte roles,
// sync bytes, frame positions and the per-byte result word.
// ----------------------------------------------------------------------------
package ubxfr_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 16;
  localparam int unsigned PosW  = LenW + 1;

  localparam logic [ByteW-1:0] SyncFirst  = 8'hB5;
  localparam logic [ByteW-1:0] SyncSecond = 8'h62;

  localparam logic [PosW-1:0] PosHunt    = 17'd0;
  localparam logic [PosW-1:0] PosSync2   = 17'd1;
  localparam logic [PosW-1:0] PosClass   = 17'd2;
  localparam logic [PosW-1:0] PosId      = 17'd3;
  localparam logic [PosW-1:0] PosLenLo   = 17'd4;
  localparam logic [PosW-1:0] PosLenHi   = 17'd5;
  localparam logic [PosW-1:0] PosPayload = 17'd6;

  typedef enum logic [2:0] {
    ROLE_DISCARD = 3'd0,
    ROLE_SYNC    = 3'd1,
    ROLE_CLASS   = 3'd2,
    ROLE_ID      = 3'd3,
    ROLE_LENGTH  = 3'd4,
    ROLE_PAYLOAD = 3'd5,
    ROLE_CHECK   = 3'd6
  } role_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    role_e            byte_role;
    logic [LenW-1:0]  payload_offset;
    logic [ByteW-1:0] frame_class;
    logic [ByteW-1:0] frame_id;
    logic [LenW-1:0]  payload_length;
    logic             frame_end;
    logic             frame_good;
  } res_t;

endpackage

@@ src/ubx_frame_receiver_top.sv @@
// ----------------------------------------------------------------------------
// ubx_frame_receiver_top
// Binary GNSS frame receiver with Fletcher-8 check.
//
// Input channel (in_valid_i / in_ready_o / rx_byte_i) takes one received
// word per cycle while in_ready_o is high. Output channel (out_valid_o /
// out_ready_i) returns one result word per input word: the byte, its role,
// payload offset, held class, id and length, and frame end / good flags on
// the last check byte. The word sits in the input register, then moves
// through the parser into the result register. Throughput is one word per
// cycle while the output does not stall; the position counter and the two
// 8-bit sums update once per word. When the receiver stalls, the result
// register holds, the input register fills, and in_ready_o drops; nothing
// is lost.
// Reset empties both registers and sends the parser back to sync hunting
// with all sums and held fields cleared.
// ----------------------------------------------------------------------------
module ubx_frame_receiver_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  data_byte_o,
  output logic [2:0]  byte_role_o,
  output logic [15:0] payload_offset_o,
  output logic [7:0]  frame_class_o,
  output logic [7:0]  frame_id_o,
  output logic [15:0] payload_length_o,
  output logic        frame_end_o,
  output logic        frame_good_o
);
  import ubxfr_pkg::*;

  logic             s1_valid;
  logic [ByteW-1:0] s1_byte;
  logic             out_free;
  logic             advance;
  res_t             res_d;
  res_t             res_q;

  assign advance = s1_valid && out_free;

  ubxfr_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .advance_i  (advance),
    .valid_o    (s1_valid),
    .byte_o     (s1_byte)
  );

  ubxfr_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .byte_i    (s1_byte),
    .res_o     (res_d)
  );

  ubxfr_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_valid),
    .res_i       (res_d),
    .ready_o     (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_q)
  );

  assign data_byte_o      = res_q.data_byte;
  assign byte_role_o      = res_q.byte_role;
  assign payload_offset_o = res_q.payload_offset;
  assign frame_class_o    = res_q.frame_class;
  assign frame_id_o       = res_q.frame_id;
  assign payload_length_o = res_q.payload_length;
  assign frame_end_o      = res_q.frame_end;
  assign frame_good_o     = res_q.frame_good;

endmodule

@@ src/ubxfr_in_stage.sv @@
// ----------------------------------------------------------------------------
// ubxfr_in_stage
// Input register: captures one received byte and holds it until the parser
// moves it on.
// ----------------------------------------------------------------------------
module ubxfr_in_stage (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ubxfr_pkg::ByteW-1:0]  rx_byte_i,
  input  logic                         advance_i,
  output logic                         valid_o,
  output logic [ubxfr_pkg::ByteW-1:0]  byte_o
);
  import ubxfr_pkg::*;

  logic             valid_q;
  logic [ByteW-1:0] byte_q;

  assign in_ready_o = !valid_q || advance_i;
  assign valid_o    = valid_q;
  assign byte_o     = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= rx_byte_i;
    end
  end

endmodule

@@ src/ubxfr_parser.sv @@
// ----------------------------------------------------------------------------
// ubxfr_parser
// Frame tracker: position counter, Fletcher-8 sums and held header fields.
// Classifies one byte per advance and builds its result word.
// ----------------------------------------------------------------------------
module ubxfr_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         advance_i,
  input  logic [ubxfr_pkg::ByteW-1:0]  byte_i,
  output ubxfr_pkg::res_t              res_o
);
  import ubxfr_pkg::*;

  logic [PosW-1:0]  pos_q, pos_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [ByteW-1:0] sum_a_q, sum_a_d;
  logic [ByteW-1:0] sum_b_q, sum_b_d;
  logic [ByteW-1:0] ck_a_q, ck_a_d;
  logic [ByteW-1:0] class_q, class_d;
  logic [ByteW-1:0] id_q, id_d;

  logic [PosW-1:0]  check_first;
  logic [ByteW-1:0] add_a;
  logic [ByteW-1:0] add_b;
  logic             do_sum;
  role_e            role;
  logic [LenW-1:0]  offset;
  logic             frame_end;
  logic             frame_good;

  assign check_first = PosPayload + {1'b0, len_q};
  assign add_a       = sum_a_q + byte_i;
  assign add_b       = sum_b_q + add_a;

  always_comb begin
    pos_d      = pos_q;
    len_d      = len_q;
    class_d    = class_q;
    id_d       = id_q;
    ck_a_d     = ck_a_q;
    sum_a_d    = sum_a_q;
    sum_b_d    = sum_b_q;
    do_sum     = 1'b0;
    role       = ROLE_DISCARD;
    offset     = '0;
    frame_end  = 1'b0;
    frame_good = 1'b0;
    if (pos_q == PosHunt) begin
      if (byte_i == SyncFirst) begin
        role    = ROLE_SYNC;
        sum_a_d = '0;
        sum_b_d = '0;
        class_d = '0;
        id_d    = '0;
        len_d   = '0;
        pos_d   = PosSync2;
      end
    end else if (pos_q == PosSync2) begin
      if (byte_i == SyncSecond) begin
        role  = ROLE_SYNC;
        pos_d = PosClass;
      end else begin
        pos_d = PosHunt;
      end
    end else if (pos_q == PosClass) begin
      role    = ROLE_CLASS;
      class_d = byte_i;
      do_sum  = 1'b1;
      pos_d   = PosId;
    end else if (pos_q == PosId) begin
      role   = ROLE_ID;
      id_d   = byte_i;
      do_sum = 1'b1;
      pos_d  = PosLenLo;
    end else if (pos_q == PosLenLo) begin
      role   = ROLE_LENGTH;
      len_d  = {{(LenW-ByteW){1'b0}}, byte_i};
      do_sum = 1'b1;
      pos_d  = PosLenHi;
    end else if (pos_q == PosLenHi) begin
      role   = ROLE_LENGTH;
      len_d  = {byte_i, len_q[ByteW-1:0]};
      do_sum = 1'b1;
      pos_d  = PosPayload;
    end else if (pos_q < check_first) begin
      role   = ROLE_PAYLOAD;
      offset = LenW'(pos_q - PosPayload);
      do_sum = 1'b1;
      pos_d  = pos_q + 1'b1;
    end else if (pos_q == check_first) begin
      role   = ROLE_CHECK;
      ck_a_d = byte_i;
      pos_d  = pos_q + 1'b1;
    end else begin
      role       = ROLE_CHECK;
      frame_end  = 1'b1;
      frame_good = (ck_a_q == sum_a_q) && (byte_i == sum_b_q);
      pos_d      = PosHunt;
    end
    if (do_sum) begin
      sum_a_d = add_a;
      sum_b_d = add_b;
    end
  end

  always_comb begin
    res_o.data_byte      = byte_i;
    res_o.byte_role      = role;
    res_o.payload_offset = offset;
    res_o.frame_end      = frame_end;
    res_o.frame_good     = frame_good;
    if (role == ROLE_DISCARD) begin
      res_o.frame_class    = '0;
      res_o.frame_id       = '0;
      res_o.payload_length = '0;
    end else begin
      res_o.frame_class    = class_d;
      res_o.frame_id       = id_d;
      res_o.payload_length = len_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= PosHunt;
      len_q   <= '0;
      sum_a_q <= '0;
      sum_b_q <= '0;
      ck_a_q  <= '0;
      class_q <= '0;
      id_q    <= '0;
    end else if (advance_i) begin
      pos_q   <= pos_d;
      len_q   <= len_d;
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
      ck_a_q  <= ck_a_d;
      class_q <= class_d;
      id_q    <= id_d;
    end
  end

  a_good_needs_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.frame_good |-> res_o.frame_end)
    else $error("frame_good without frame_end");

  a_end_is_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.frame_end |-> (res_o.byte_role == ROLE_CHECK))
    else $error("frame_end on a non-check byte");

  a_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q >= PosPayload) |-> (pos_q <= check_first + 1'b1))
    else $error("frame position beyond the check bytes");

  a_end_rehunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && res_o.frame_end) |=> (pos_q == PosHunt))
    else $error("no return to hunting after frame end");

endmodule

@@ src/ubxfr_out_stage.sv @@
// ----------------------------------------------------------------------------
// ubxfr_out_stage
// Result register: holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module ubxfr_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  ubxfr_pkg::res_t  res_i,
  output logic             ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ubxfr_pkg::res_t  res_o
);
  import ubxfr_pkg::*;

  logic valid_q;
  res_t res_q;

  assign ready_o     = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && ready_o) begin
      res_q <= res_i;
    end
  end

endmodule
